// ----- rtl/cplu_pkg.sv -----
// Package for the contact-process lattice update core.
// Word types, register indexes, codes, controller states and reset values.
// No dependencies.
package cplu_pkg;

  // Field widths fixed by the word formats
  localparam int unsigned SITE_W    = 16;
  localparam int unsigned DIR_W     = 2;
  localparam int unsigned CHANCE_W  = 16;
  localparam int unsigned THR_W     = 17;
  localparam int unsigned CNT_W     = 17;
  localparam int unsigned CFG_IDX_W = 1;

  // Number of sites an index word can reach
  localparam int unsigned SITE_SPAN = 1 << SITE_W;

  // Default lattice side
  localparam int unsigned SIDE_DEFAULT = 256;

  // Reciprocal used to split a site index into row and column
  localparam int unsigned RECIP_SH = 32;
  localparam int unsigned RECIP_W  = 31;

  // Register indexes on the write port
  localparam logic [CFG_IDX_W-1:0] REG_CLEAR_THR  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SPREAD_THR = 1'b1;

  // Register reset values (Q1.16)
  localparam logic [THR_W-1:0] CLEAR_THR_RESET  = 17'd32768;
  localparam logic [THR_W-1:0] SPREAD_THR_RESET = 17'd65536;

  // Operation codes
  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_LOAD   = 1'b1;

  // Neighbour direction codes
  localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd0;
  localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd1;
  localparam logic [DIR_W-1:0] DIR_ABOVE = 2'd2;
  localparam logic [DIR_W-1:0] DIR_BELOW = 2'd3;

  // Input word
  typedef struct packed {
    logic                operation;
    logic [SITE_W-1:0]   site_addr;
    logic [DIR_W-1:0]    direction;
    logic [CHANCE_W-1:0] chance;
    logic                load_value;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic             site_after;
    logic             changed;
    logic [CNT_W-1:0] occupied_count;
  } out_word_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SITE,
    ST_NBR,
    ST_RDNB,
    ST_DONE
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;
    logic clear;
    logic rd_site;
    logic calc_nb;
    logic rd_nb;
    logic finish;
  } ctrl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic clear_last;
  } dp_status_t;

endpackage

// ----- rtl/cplu_ram.sv -----
// Generic single-port RAM with registered read data.
// No dependencies.
module cplu_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write, and read old contents
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/cplu_ctrl.sv -----
// Controller for the lattice update core: clearing pass and per-word sequence.
// Depends on cplu_pkg.
module cplu_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  cplu_pkg::dp_status_t status_i,
  output cplu_pkg::ctrl_cmd_t  cmd_o
);

  cplu_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cplu_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = 1'b1;
    unique case (state_q)
      cplu_pkg::ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (status_i.clear_last) begin
          state_d = cplu_pkg::ST_IDLE;
        end
      end
      cplu_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.capture = 1'b1;
          state_d       = cplu_pkg::ST_SITE;
        end
      end
      cplu_pkg::ST_SITE: begin
        cmd_o.rd_site = 1'b1;
        state_d       = cplu_pkg::ST_NBR;
      end
      cplu_pkg::ST_NBR: begin
        cmd_o.calc_nb = 1'b1;
        state_d       = cplu_pkg::ST_RDNB;
      end
      cplu_pkg::ST_RDNB: begin
        cmd_o.rd_nb = 1'b1;
        state_d     = cplu_pkg::ST_DONE;
      end
      cplu_pkg::ST_DONE: begin
        // write-back; next word may be taken in the same cycle
        busy         = 1'b0;
        cmd_o.finish = 1'b1;
        if (start) begin
          cmd_o.capture = 1'b1;
          state_d       = cplu_pkg::ST_SITE;
        end else begin
          state_d = cplu_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = cplu_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/cplu_dp.sv -----
// Datapath for the lattice update core: lattice RAM, neighbour address,
// decision, running count, threshold registers and result register.
// Depends on cplu_pkg and cplu_ram.
module cplu_dp #(
  parameter int unsigned SIDE = cplu_pkg::SIDE_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  cplu_pkg::ctrl_cmd_t                 cmd_i,
  output cplu_pkg::dp_status_t                status_o,
  input  cplu_pkg::in_word_t                  item_i,
  output logic                                done_o,
  output cplu_pkg::out_word_t                 result_o,
  input  logic                                cfg_we_i,
  input  logic [cplu_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [cplu_pkg::THR_W-1:0]          cfg_wdata_i
);

  localparam int unsigned SITES = SIDE * SIDE;
  // only the first SITE_SPAN sites can be named by an index word
  localparam int unsigned DEPTH = (SITES < cplu_pkg::SITE_SPAN) ? SITES
                                                                : cplu_pkg::SITE_SPAN;
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned NW = $clog2(SITES);
  localparam int unsigned XW = NW + 1;
  localparam int unsigned RW = $clog2(SIDE);
  localparam int unsigned SW = cplu_pkg::SITE_W;
  localparam int unsigned PW = SW + cplu_pkg::RECIP_W;
  localparam longint unsigned RECIP_L =
    ((64'd1 << cplu_pkg::RECIP_SH) + 64'(SIDE) - 64'd1) / 64'(SIDE);
  localparam logic [cplu_pkg::RECIP_W-1:0] RECIP = cplu_pkg::RECIP_W'(RECIP_L);

  // registers
  cplu_pkg::in_word_t                item_q;
  logic [SW-1:0]                     row_q;
  logic                              site_bit_q;
  logic [AW-1:0]                     nb_addr_q, nb_addr_d;
  logic                              nb_ok_q, nb_ok_d;
  logic [AW-1:0]                     clr_addr_q;
  logic [cplu_pkg::CNT_W-1:0]        cnt_q, cnt_d;
  logic [cplu_pkg::THR_W-1:0]        clr_thr_q, spr_thr_q;
  logic                              done_q;
  cplu_pkg::out_word_t               result_q, result_d;

  // RAM side
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic          ram_wdata;
  logic          ram_rdata;

  // neighbour arithmetic
  logic [PW-1:0]   q_prod;
  logic [2*SW-1:0] row_prod;
  logic [SW-1:0]   col_full;
  logic [RW-1:0]   col;
  logic [XW-1:0]   site_x, nb;
  logic            site_ok;

  // decision
  logic prev_bit, after, nb_bit, changed;

  cplu_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_lattice (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // threshold registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_thr_q <= cplu_pkg::CLEAR_THR_RESET;
      spr_thr_q <= cplu_pkg::SPREAD_THR_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        cplu_pkg::REG_CLEAR_THR:  clr_thr_q <= cfg_wdata_i;
        cplu_pkg::REG_SPREAD_THR: spr_thr_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // site in range of the lattice
  assign site_ok = {1'b0, item_q.site_addr} < (SW + 1)'(DEPTH);

  // row by reciprocal multiply, column from the remainder
  assign q_prod   = item_q.site_addr * RECIP;
  assign row_prod = row_q * SW'(SIDE);
  assign col_full = item_q.site_addr - row_prod[SW-1:0];
  assign col      = col_full[RW-1:0];
  assign site_x   = XW'(item_q.site_addr);

  // neighbour index with wrap-around
  always_comb begin
    case (item_q.direction)
      cplu_pkg::DIR_LEFT:
        nb = (col == '0) ? site_x + XW'(SIDE - 1) : site_x - XW'(1);
      cplu_pkg::DIR_RIGHT:
        nb = (col == RW'(SIDE - 1)) ? site_x - XW'(SIDE - 1) : site_x + XW'(1);
      cplu_pkg::DIR_ABOVE:
        nb = (site_x < XW'(SIDE)) ? site_x + XW'(SITES - SIDE) : site_x - XW'(SIDE);
      default: // below
        nb = (site_x >= XW'(SITES - SIDE)) ? site_x - XW'(SITES - SIDE)
                                           : site_x + XW'(SIDE);
    endcase
    // sites past the index span are never written and stay empty
    nb_ok_d   = nb < XW'(DEPTH);
    nb_addr_d = nb[AW-1:0];
  end

  // update decision and count
  always_comb begin
    prev_bit = site_bit_q;
    nb_bit   = nb_ok_q & ram_rdata;
    if (item_q.operation == cplu_pkg::OP_LOAD) begin
      after = item_q.load_value;
    end else if (prev_bit) begin
      after = !({1'b0, item_q.chance} < clr_thr_q);
    end else begin
      after = nb_bit && ({1'b0, item_q.chance} < spr_thr_q);
    end
    if (!site_ok) begin
      after    = 1'b0;
      prev_bit = 1'b0;
    end
    changed = after ^ prev_bit;
    cnt_d   = cnt_q;
    if (after && !prev_bit) begin
      cnt_d = cnt_q + cplu_pkg::CNT_W'(1);
    end else if (!after && prev_bit) begin
      cnt_d = cnt_q - cplu_pkg::CNT_W'(1);
    end
    result_d.site_after     = after;
    result_d.changed        = changed;
    result_d.occupied_count = cnt_d;
  end

  // RAM port sharing
  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = 1'b0;
    ram_addr  = item_q.site_addr[AW-1:0];
    if (cmd_i.clear) begin
      ram_we   = 1'b1;
      ram_addr = clr_addr_q;
    end else if (cmd_i.rd_nb) begin
      ram_addr = nb_addr_q;
    end else if (cmd_i.finish) begin
      ram_we    = site_ok && changed;
      ram_wdata = after;
    end
  end

  assign status_o.clear_last = (clr_addr_q == AW'(DEPTH - 1));

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      cnt_q      <= '0;
      done_q     <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        clr_addr_q <= clr_addr_q + AW'(1);
      end
      if (cmd_i.finish) begin
        cnt_q <= cnt_d;
      end
      done_q <= cmd_i.finish;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= item_i;
    end
    if (cmd_i.rd_site) begin
      row_q <= SW'(q_prod[PW-1:cplu_pkg::RECIP_SH]);
    end
    if (cmd_i.calc_nb) begin
      site_bit_q <= ram_rdata;
      nb_addr_q  <= nb_addr_d;
      nb_ok_q    <= nb_ok_d;
    end
    if (cmd_i.finish) begin
      result_q <= result_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

// ----- rtl/contact_process_lattice_update_core.sv -----
// Top level of the contact-process lattice update core.
// Depends on cplu_pkg, cplu_ctrl and cplu_dp (which holds cplu_ram).
//
// A word is taken at a rising edge with start high and busy low; its result
// is on result_o with done_o high for one cycle and is captured in that cycle,
// since the receiver cannot hold it off. A new word is taken only once the
// last is in write-back: the single-port lattice RAM is read for the site,
// then for the neighbour, then written back, with the neighbour address formed
// from row and column between the two reads. After reset the block stays busy
// while it clears the lattice one site a cycle; threshold writes are taken at
// any time but belong in idle periods. Sites beyond index 65535 cannot be named
// and always read as empty.
module contact_process_lattice_update_core #(
  parameter int unsigned SIDE = cplu_pkg::SIDE_DEFAULT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  cplu_pkg::in_word_t             item_i,
  output logic                           done_o,
  output cplu_pkg::out_word_t            result_o,
  input  logic                           cfg_we_i,
  input  logic [cplu_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [cplu_pkg::THR_W-1:0]     cfg_wdata_i
);

  cplu_pkg::ctrl_cmd_t  cmd;
  cplu_pkg::dp_status_t status;

  cplu_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (status),
    .cmd_o    (cmd)
  );

  cplu_dp #(
    .SIDE (SIDE)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .item_i      (item_i),
    .done_o      (done_o),
    .result_o    (result_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // every accepted word gives its result on done_o
  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##5 done_o)
    else $error("result missing five cycles after accept");

  // results never come back to back
  a_result_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobes in consecutive cycles");

  // a site that just became occupied leaves a non-zero count
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.changed && result_o.site_after)
      |-> (result_o.occupied_count != '0))
    else $error("count zero after a site became occupied");

endmodule
